// ----- rtl/tsct_pkg.sv -----
// ----------------------------------------------------------------------------
// tsct_pkg
// Types, constants and the reciprocal-factorial table shared by the Taylor
// series sine/cosine/tangent pipeline.
// ----------------------------------------------------------------------------
package tsct_pkg;

   localparam int MAX_TERMS    = 6;
   localparam int SERIES_CELLS = 2 * MAX_TERMS;
   localparam int DIV_STEPS    = 64;
   localparam int CELL_IDX_W   = 4;
   localparam int TERMS_W      = 3;

   localparam logic signed [63:0] POW_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] POW_MIN = -64'sh0000_8000_0000_0000;
   localparam logic signed [63:0] VAL_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] VAL_MIN = -64'sh0000_0000_8000_0000;
   localparam logic signed [47:0] POW_ONE = 48'sh00_0010_000000;

   typedef enum logic [1:0] {
      ACT_SINE    = 2'd0,
      ACT_COSINE  = 2'd1,
      ACT_TANGENT = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_SAT      = 2'd1,
      STAT_ZERO_COS = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]          action;
      logic signed [15:0]  angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  value;
      logic [1:0]          status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]          action;
      logic signed [15:0]  angle;
      logic signed [47:0]  pw;
      logic signed [63:0]  sn;
      logic signed [63:0]  cs;
   } series_type;

   typedef struct packed {
      logic [64:0]         rem;
      logic [63:0]         num;
      logic [63:0]         den;
      logic [63:0]         quo;
      logic                neg;
      logic                tan_live;
      logic signed [31:0]  value;
      logic [1:0]          status;
   } div_type;

   // floor(2^32 / p!), the last entry serves every higher power
   function automatic logic [32:0] recip_fact(input logic [CELL_IDX_W-1:0] p);
      logic [32:0] r;
      unique case (p)
         4'd0:    r = 33'd4294967296;
         4'd1:    r = 33'd4294967296;
         4'd2:    r = 33'd2147483648;
         4'd3:    r = 33'd715827882;
         4'd4:    r = 33'd178956970;
         4'd5:    r = 33'd35791394;
         4'd6:    r = 33'd5965232;
         4'd7:    r = 33'd852176;
         4'd8:    r = 33'd106522;
         4'd9:    r = 33'd11835;
         4'd10:   r = 33'd1183;
         default: r = 33'd107;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/tsct_series_cell.sv -----
// ----------------------------------------------------------------------------
// tsct_series_cell
// One power of the series: adds its term to the sine or cosine sum when the
// cell is below 2*terms, and passes the next power on to its neighbour.
// ----------------------------------------------------------------------------
module tsct_series_cell import tsct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CELL_IDX_W-1:0] cell_index,
   input  logic [TERMS_W-1:0]    terms,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  series_type            up_data,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output series_type            dn_data
);

   logic        valid_ff;
   series_type  data_ff;
   series_type  data_in;

   logic [47:0]        mag;
   logic [32:0]        recip;
   logic [64:0]        prod_hi;
   logic [63:0]        prod_lo;
   logic [65:0]        acc;
   logic signed [63:0] tmag;
   logic signed [63:0] term;
   logic signed [63:0] prod;
   logic signed [63:0] shifted;
   logic               active;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      mag     = up_data.pw[47] ? 48'(-up_data.pw) : 48'(up_data.pw);
      recip   = recip_fact(cell_index);
      prod_hi = 65'(mag) * 65'(recip[32:16]);
      prod_lo = 64'(mag) * 64'(recip[15:0]);
      acc     = 66'(prod_hi) + 66'(prod_lo[63:16]);
      tmag    = 64'(acc[65:16]);
      // series sign alternates every second power
      term    = (up_data.pw[47] != cell_index[1]) ? -tmag : tmag;
      active  = cell_index[CELL_IDX_W-1:1] < terms;

      prod    = up_data.pw * up_data.angle;
      shifted = prod >>> 13;

      data_in = up_data;
      if (shifted > POW_MAX) begin
         data_in.pw = POW_MAX[47:0];
      end else if (shifted < POW_MIN) begin
         data_in.pw = POW_MIN[47:0];
      end else begin
         data_in.pw = shifted[47:0];
      end
      if (active) begin
         if (cell_index[0]) begin
            data_in.sn = up_data.sn + term;
         end else begin
            data_in.cs = up_data.cs + term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- rtl/tsct_div_cell.sv -----
// ----------------------------------------------------------------------------
// tsct_div_cell
// One restoring division step: one quotient bit of the tangent per cell.
// ----------------------------------------------------------------------------
module tsct_div_cell import tsct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  div_type up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output div_type dn_data
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   logic [64:0] rem_sh;
   logic        ge;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      rem_sh  = {up_data.rem[63:0], up_data.num[63]};
      ge      = rem_sh >= {1'b0, up_data.den};
      data_in = up_data;
      data_in.rem = ge ? rem_sh - {1'b0, up_data.den} : rem_sh;
      data_in.num = {up_data.num[62:0], 1'b0};
      data_in.quo = {up_data.quo[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- rtl/taylor_sine_cosine_tangent.sv -----
// ----------------------------------------------------------------------------
// taylor_sine_cosine_tangent
// Truncated Taylor series sine, cosine and tangent of a Q3.13 angle.
// ----------------------------------------------------------------------------
// Usage:
//   req_ beats carry an action code and a Q3.13 angle; rsp_ beats carry the
//   Q16.16 value and a status code (ok, saturated, tangent with zero cosine).
//   The csr_ port holds term_count (addresses 0 to 3), reset value 6.
// Path and throughput:
//   every item passes 12 series cells (one power each), one division step
//   cell per quotient bit (64) and the output register on the way from an
//   accepted req_ beat to rsp_valid. One item is accepted every cycle while
//   req_stall is low; the rate is set by the cell chain, one item per cell.
// Stalls:
//   each cell has its own valid bit, so while rsp_stall is high the result
//   waits in the output register and the chain keeps filling its empty cells;
//   req_stall rises only once every cell up to the input holds an item.
// Reset:
//   synchronous; all cells empty, term_count back to 6.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_tangent import tsct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [TERMS_W-1:0] term_count_ff;
   logic [TERMS_W-1:0] terms_eff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {29'd0, term_count_ff};
   assign terms_eff  = (term_count_ff > TERMS_W'(MAX_TERMS)) ?
                       TERMS_W'(MAX_TERMS) : term_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TERMS_W'(MAX_TERMS);
      end else if (csr_wr && !csr_paddr[2]) begin
         term_count_ff <= csr_pwdata[TERMS_W-1:0];
      end
   end

   // series chain
   logic       ser_valid [SERIES_CELLS+1];
   logic       ser_ready [SERIES_CELLS+1];
   series_type ser_data  [SERIES_CELLS+1];

   always_comb begin
      ser_data[0].action = req_data.action;
      ser_data[0].angle  = req_data.angle;
      ser_data[0].pw     = POW_ONE;
      ser_data[0].sn     = 64'sd0;
      ser_data[0].cs     = 64'sd0;
   end
   assign ser_valid[0] = req_valid;
   assign req_stall    = !ser_ready[0];

   for (genvar i = 0; i < SERIES_CELLS; i++) begin : g_series
      tsct_series_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CELL_IDX_W'(i)),
         .terms      (terms_eff),
         .up_valid   (ser_valid[i]),
         .up_ready   (ser_ready[i]),
         .up_data    (ser_data[i]),
         .dn_valid   (ser_valid[i+1]),
         .dn_ready   (ser_ready[i+1]),
         .dn_data    (ser_data[i+1])
      );
   end

   // sine and cosine results, tangent operands
   logic       div_valid [DIV_STEPS+1];
   logic       div_ready [DIV_STEPS+1];
   div_type    div_data  [DIV_STEPS+1];

   series_type         s;
   logic signed [63:0] sel_sum;
   logic signed [63:0] sel_sh;
   logic signed [63:0] num;

   always_comb begin
      s       = ser_data[SERIES_CELLS];
      sel_sum = (s.action == ACT_COSINE) ? s.cs : s.sn;
      sel_sh  = sel_sum >>> 12;
      num     = s.sn <<< 16;

      div_data[0].rem      = 65'd0;
      div_data[0].quo      = 64'd0;
      div_data[0].num      = num[63] ? 64'(-num) : 64'(num);
      div_data[0].den      = s.cs[63] ? 64'(-s.cs) : 64'(s.cs);
      div_data[0].neg      = num[63] != s.cs[63];
      div_data[0].tan_live = (s.action == ACT_TANGENT) && (s.cs != 64'sd0);
      div_data[0].value    = 32'sd0;
      div_data[0].status   = STAT_OK;
      unique case (action_type'(s.action))
         ACT_SINE, ACT_COSINE: begin
            if (sel_sh > VAL_MAX) begin
               div_data[0].value  = VAL_MAX[31:0];
               div_data[0].status = STAT_SAT;
            end else if (sel_sh < VAL_MIN) begin
               div_data[0].value  = VAL_MIN[31:0];
               div_data[0].status = STAT_SAT;
            end else begin
               div_data[0].value  = sel_sh[31:0];
            end
         end
         ACT_TANGENT: begin
            if (s.cs == 64'sd0) begin
               div_data[0].status = STAT_ZERO_COS;
            end
         end
         ACT_NONE: begin
            div_data[0].value = 32'sd0;
         end
      endcase
   end
   assign div_valid[0]         = ser_valid[SERIES_CELLS];
   assign ser_ready[SERIES_CELLS] = div_ready[0];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      tsct_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[j]),
         .up_ready (div_ready[j]),
         .up_data  (div_data[j]),
         .dn_valid (div_valid[j+1]),
         .dn_ready (div_ready[j+1]),
         .dn_data  (div_data[j+1])
      );
   end

   // output register
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;
   rsp_type  rsp_data_in;
   div_type  d;

   assign div_ready[DIV_STEPS] = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data             = rsp_data_ff;

   always_comb begin
      d                  = div_data[DIV_STEPS];
      rsp_data_in.value  = d.value;
      rsp_data_in.status = d.status;
      if (d.tan_live) begin
         if (d.neg) begin
            if (d.quo > 64'h8000_0000) begin
               rsp_data_in.value  = VAL_MIN[31:0];
               rsp_data_in.status = STAT_SAT;
            end else begin
               rsp_data_in.value  = 32'(-d.quo);
            end
         end else begin
            if (d.quo > 64'h7FFF_FFFF) begin
               rsp_data_in.value  = VAL_MAX[31:0];
               rsp_data_in.status = STAT_SAT;
            end else begin
               rsp_data_in.value  = d.quo[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready[DIV_STEPS]) begin
         rsp_valid_ff <= div_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready[DIV_STEPS] && div_valid[DIV_STEPS]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_zero_cos_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_ZERO_COS |-> rsp_data.value == 32'sd0)
      else $error("zero cosine status with nonzero value");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_SAT |->
      rsp_data.value == VAL_MAX[31:0] || rsp_data.value == VAL_MIN[31:0])
      else $error("saturated status with value off the range limits");

   a_reset_terms: assert property (@(posedge clock)
      !reset && $past(reset) |-> term_count_ff == TERMS_W'(MAX_TERMS))
      else $error("term count not restored by reset");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && !csr_paddr[2] |=> term_count_ff == $past(csr_pwdata[TERMS_W-1:0]))
      else $error("term count write lost");

   a_out_full_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && div_valid[DIV_STEPS] |=> rsp_valid)
      else $error("held result dropped from the output register");

endmodule

// ----- dv/taylor_sine_cosine_tangent_tb.sv -----
// ----------------------------------------------------------------------------
// taylor_sine_cosine_tangent_tb
// Drives angle/action beats into the Taylor series pipeline under several
// term_count settings, predicts each result in a local series model and
// compares every rsp_ beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_tangent_tb;
   import tsct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY    = 80;
   localparam int IDLE_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rsp_type     trig_expected[$];
   logic [2:0]  terms_setting = 3'd6;
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          hold_rsp = 1'b0;
   int          hold_len = 0;

   taylor_sine_cosine_tangent u_top (.*);

   always #5 clock = ~clock;

   // powers, reciprocal factorials and sums at the block's widths
   function automatic logic [32:0] inv_fact(int p);
      case (p)
         0, 1:    return 33'd4294967296;
         2:       return 33'd2147483648;
         3:       return 33'd715827882;
         4:       return 33'd178956970;
         5:       return 33'd35791394;
         6:       return 33'd5965232;
         7:       return 33'd852176;
         8:       return 33'd106522;
         9:       return 33'd11835;
         10:      return 33'd1183;
         default: return 33'd107;
      endcase
   endfunction

   function automatic rsp_type trig_predict(req_type rq, logic [2:0] terms);
      rsp_type r;
      logic signed [63:0] pw, prod, sn, cs, t, v, num, q;
      logic [63:0] m, rc, un, ud, uq;
      int n;
      bit neg;
      n  = (terms > MAX_TERMS) ? MAX_TERMS : terms;
      pw = 64'sd1 <<< 28;
      sn = 0;
      cs = 0;
      r  = '0;
      for (int p = 0; p < 2 * n; p++) begin
         m  = pw[63] ? -pw : pw;
         rc = {31'd0, inv_fact(p)};
         t  = (m * (rc >> 16) + ((m * (rc & 64'hFFFF)) >> 16)) >> 16;
         if (pw[63] != ((p >> 1) & 1)) t = -t;
         if (p & 1) sn += t; else cs += t;
         prod = (pw * 64'(rq.angle)) >>> 13;
         if (prod > POW_MAX) prod = POW_MAX;
         if (prod < POW_MIN) prod = POW_MIN;
         pw = prod;
      end
      case (action_type'(rq.action))
         ACT_SINE, ACT_COSINE: begin
            v = ((rq.action == ACT_SINE) ? sn : cs) >>> 12;
            r.status = STAT_OK;
            if (v > VAL_MAX) begin v = VAL_MAX; r.status = STAT_SAT; end
            if (v < VAL_MIN) begin v = VAL_MIN; r.status = STAT_SAT; end
            r.value = v[31:0];
         end
         ACT_TANGENT: begin
            if (cs == 0) begin
               r.value  = '0;
               r.status = STAT_ZERO_COS;
            end else begin
               num = sn * 65536;
               un  = num[63] ? -num : num;
               ud  = cs[63] ? -cs : cs;
               uq  = un / ud;
               neg = num[63] != cs[63];
               r.status = STAT_OK;
               if (neg) begin
                  if (uq > 64'h8000_0000) begin uq = 64'h8000_0000; r.status = STAT_SAT; end
                  q = -$signed(uq);
               end else begin
                  if (uq > 64'h7FFF_FFFF) begin uq = 64'h7FFF_FFFF; r.status = STAT_SAT; end
                  q = $signed(uq);
               end
               r.value = q[31:0];
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic send_angle(action_type act, logic signed [15:0] ang);
      req_type rq;
      rq.action = act;
      rq.angle  = ang;
      req_data  <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      trig_expected.push_back(trig_predict(rq, terms_setting));
      @(negedge clock);
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // burst of back-to-back beats keeps valid high between them
   task automatic send_burst(int count, int gap_max);
      req_type rq;
      for (int i = 0; i < count; i++) begin
         rq.action = action_type'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
         case ($urandom_range(0, 5))
            0:       rq.angle = 16'($urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000);
            1:       rq.angle = 16'($signed($urandom_range(0, 1023)) - 512);
            2:       rq.angle = 16'($signed($urandom_range(0, 25736)) - 12868);
            default: rq.angle = 16'($urandom);
         endcase
         req_data  <= rq;
         req_valid <= 1'b1;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         trig_expected.push_back(trig_predict(rq, terms_setting));
         @(negedge clock);
      end
      req_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max + 1)) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (trig_expected.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_terms(logic [2:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= '0;
      csr_pwdata  <= {29'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      terms_setting = value;
   endtask

   task automatic test_directed();
      logic signed [15:0] angles[10] = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh0001,
                                         -16'sh0001, 16'sh3244, -16'sh3244, 16'sh1922,
                                         -16'sh1922, 16'sh5555};
      foreach (angles[i])
         for (int a = 0; a < 4; a++)
            if ((i * 4 + a) % 2 == 0 || a == ACT_TANGENT) send_angle(action_type'(a), angles[i]);
      wait_drained();
   endtask

   task automatic test_terms_extremes();
      logic [2:0] settings[4] = '{3'd1, 3'd0, 3'd7, 3'd2};
      foreach (settings[s]) begin
         write_terms(settings[s]);
         send_angle(ACT_TANGENT, 16'sh7FFF);
         send_angle(ACT_SINE, -16'sh8000);
         send_angle(ACT_COSINE, 16'sh4000);
         send_angle(ACT_NONE, 16'sh1234);
         send_burst(60, 3);
         wait_drained();
      end
   endtask

   task automatic test_random_traffic();
      for (int s = 0; s < 4; s++) begin
         write_terms(3'($urandom_range(1, 6)));
         for (int b = 0; b < 60; b++) send_burst($urandom_range(1, 12), 6);
         wait_drained();
      end
      write_terms(3'd6);
   endtask

   task automatic test_backpressure();
      hold_len = 400;
      hold_rsp = 1'b1;
      send_burst(200, 0);
      wait_drained();
   endtask

   // receiver stall pattern, with a long hold-off on request
   initial begin
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            case ($urandom_range(0, 3))
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 1) == 1);
               default: rsp_stall <= ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (trig_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h", rsp_data);
         end else begin
            exp = trig_expected.pop_front();
            if (rsp_data.value !== exp.value || rsp_data.status !== exp.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                           exp.value, rsp_data.value, exp.status, rsp_data.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("taylor_sine_cosine_tangent_tb: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_terms_extremes();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      if (mismatches == 0 && trig_expected.size() == 0)
         $display("taylor_sine_cosine_tangent_tb: PASS");
      else
         $display("taylor_sine_cosine_tangent_tb: FAIL");
      $finish;
   end

endmodule
